/* hw/rtl/kepler_orbit_position_top_assert.svh */
// Assertion macros for the orbit position block.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef KEPLER_ORBIT_POSITION_TOP_ASSERT_SVH
`define KEPLER_ORBIT_POSITION_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define KOP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define KOP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/kop_pkg.sv */
// Shared types, constants and functions of the orbit position block.
// No dependencies.
package kop_pkg;

  localparam int unsigned CordicSteps = 30;
  localparam int unsigned NumTerms    = 5;
  localparam int unsigned PipeStages  = 68;

  localparam logic signed [32:0] CordicX0  = 33'sh026DD3B6A;
  localparam logic [31:0]        TwoOverPi = 32'hA2F9836E;

  // configuration register indexes
  localparam logic [2:0] REG_START_ANOMALY = 3'd0;
  localparam logic [2:0] REG_ANOMALY_RATE  = 3'd1;
  localparam logic [2:0] REG_ECCENTRICITY  = 3'd2;
  localparam logic [2:0] REG_SEMI_MAJOR    = 3'd3;
  localparam logic [2:0] REG_SEMI_MINOR    = 3'd4;
  localparam logic [2:0] REG_SPIN_RATE     = 3'd5;

  // one rotation cell's data: vector, residual angle, quadrant fold, sideband
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [33:0] z;
    logic               neg;
    logic [63:0]        tag;
  } cordic_t;

  typedef logic signed [35:0] coef_t;

  // atan(2^-i) in turns, Q0.32
  function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sh020000000;
      5'd1:  r = 34'sh012E4051E;
      5'd2:  r = 34'sh009FB385B;
      5'd3:  r = 34'sh0051111D4;
      5'd4:  r = 34'sh0028B0D43;
      5'd5:  r = 34'sh00145D7E1;
      5'd6:  r = 34'sh000A2F61E;
      5'd7:  r = 34'sh000517C55;
      5'd8:  r = 34'sh00028BE53;
      5'd9:  r = 34'sh000145F2F;
      5'd10: r = 34'sh0000A2F98;
      5'd11: r = 34'sh0000517CC;
      5'd12: r = 34'sh000028BE6;
      5'd13: r = 34'sh0000145F3;
      5'd14: r = 34'sh00000A2FA;
      5'd15: r = 34'sh00000517D;
      5'd16: r = 34'sh0000028BE;
      5'd17: r = 34'sh00000145F;
      5'd18: r = 34'sh000000A30;
      5'd19: r = 34'sh000000518;
      5'd20: r = 34'sh00000028C;
      5'd21: r = 34'sh000000146;
      5'd22: r = 34'sh0000000A3;
      5'd23: r = 34'sh000000051;
      5'd24: r = 34'sh000000029;
      5'd25: r = 34'sh000000014;
      5'd26: r = 34'sh00000000A;
      5'd27: r = 34'sh000000005;
      5'd28: r = 34'sh000000003;
      5'd29: r = 34'sh000000001;
      default: r = '0;
    endcase
    return r;
  endfunction

  // clamp to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sh07FFFFFFF) begin
      r = 32'h7FFFFFFF;
    end else if (v < -36'sh080000000) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/kop_cordic_cell.sv */
// One rotation step of the sine/cosine chain, registered.
// Depends on kop_pkg.
module kop_cordic_cell import kop_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [4:0]  step,
  input  cordic_t     d_i,
  output cordic_t     d_o
);

  cordic_t            d_r, d_nxt;
  logic signed [32:0] sx, sy;
  logic signed [33:0] ang;

  // rotate toward zero residual angle
  always_comb begin
    sx  = d_i.x >>> step;
    sy  = d_i.y >>> step;
    ang = atan_turn(step);
    d_nxt = d_i;
    if (!d_i.z[33]) begin
      d_nxt.x = d_i.x - sy;
      d_nxt.y = d_i.y + sx;
      d_nxt.z = d_i.z - ang;
    end else begin
      d_nxt.x = d_i.x + sy;
      d_nxt.y = d_i.y - sx;
      d_nxt.z = d_i.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

/* hw/rtl/kop_cordic_chain.sv */
// Quadrant fold, row of rotation cells and unfold: cos/sin of a Q0.32 turn angle.
// Depends on kop_pkg and kop_cordic_cell.
module kop_cordic_chain import kop_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        ang_i,
  input  logic [63:0]        tag_i,
  output logic signed [32:0] cos_o,
  output logic signed [32:0] sin_o,
  output logic [63:0]        tag_o
);

  cordic_t     link [CordicSteps+1];
  logic        fold;
  logic [31:0] quarter, folded;

  // angles in the left half-plane get a half turn and a sign flip
  assign quarter     = ang_i + 32'h40000000;
  assign fold        = quarter[31];
  assign folded      = fold ? (ang_i + 32'h80000000) : ang_i;
  assign link[0].x   = CordicX0;
  assign link[0].y   = '0;
  assign link[0].z   = {{2{folded[31]}}, folded};
  assign link[0].neg = fold;
  assign link[0].tag = tag_i;

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    kop_cordic_cell u_cell (
      .clk  (clk),
      .en   (en),
      .step (5'(g)),
      .d_i  (link[g]),
      .d_o  (link[g+1])
    );
  end

  // undo the fold
  assign cos_o = link[CordicSteps].neg ? -link[CordicSteps].x : link[CordicSteps].x;
  assign sin_o = link[CordicSteps].neg ? -link[CordicSteps].y : link[CordicSteps].y;
  assign tag_o = link[CordicSteps].tag;

endmodule

/* hw/rtl/kop_coef.sv */
// Series coefficients from the eccentricity register, free-running pipeline.
// Depends on kop_pkg.
module kop_coef import kop_pkg::*; (
  input  logic        clk,
  input  logic [15:0] ecc,
  output coef_t       cf_o [NumTerms]
);

  logic [31:0] e1_r, e2_r, e3_r, e4_r, e5_r;
  logic [63:0] p2, p3, p4, p5;
  logic [29:0] v96a_r;
  logic [32:0] v24_r;
  logic [33:0] v12_r, v96b_r;
  logic [36:0] v960_r;
  logic [62:0] m96a_r;
  logic [66:0] m24_r;
  logic [68:0] m12_r, m96b_r;
  logic [74:0] m960_r;
  logic [34:0] f5e5;
  logic [35:0] f11e4;
  logic [35:0] f13e3;
  logic [38:0] f103e4;
  logic [42:0] f1097e5;
  logic [37:0] f43e5;
  logic [34:0] f5e2;
  coef_t       cf_r [NumTerms];

  // powers of e, Q0.32, truncated
  assign p2 = e1_r * e1_r;
  assign p3 = e2_r * e1_r;
  assign p4 = e3_r * e1_r;
  assign p5 = e4_r * e1_r;

  // constant scalings, pre-shifted by the power-of-two part of each divisor
  assign f5e5    = 35'(e5_r) * 35'd5;
  assign f11e4   = 36'(e4_r) * 36'd11;
  assign f13e3   = 36'(e3_r) * 36'd13;
  assign f103e4  = 39'(e4_r) * 39'd103;
  assign f1097e5 = 43'(e5_r) * 43'd1097;
  assign f43e5   = 38'(e5_r) * 38'd43;
  assign f5e2    = 35'(e2_r) * 35'd5;

  always_ff @(posedge clk) begin
    e1_r <= {ecc, 16'h0000};
    e2_r <= p2[63:32];
    e3_r <= p3[63:32];
    e4_r <= p4[63:32];
    e5_r <= p5[63:32];
    v96a_r <= f5e5[34:5];
    v24_r  <= f11e4[35:3];
    v12_r  <= f13e3[35:2];
    v96b_r <= f103e4[38:5];
    v960_r <= f1097e5[42:6];
    // odd divisors by reciprocal multiply, exact for these operand widths
    m96a_r <= 63'(v96a_r) * 63'h0_5555_5556;
    m24_r  <= 67'(v24_r)  * 67'h2_AAAA_AAAB;
    m12_r  <= 69'(v12_r)  * 69'h5_5555_5556;
    m96b_r <= 69'(v96b_r) * 69'h5_5555_5556;
    m960_r <= 75'(v960_r) * 75'h22_2222_2223;
    cf_r[0] <= 36'({e1_r, 1'b0}) - 36'(e3_r[31:2]) + 36'(m96a_r[62:32]);
    cf_r[1] <= 36'(f5e2[34:2]) - 36'(m24_r[66:35]);
    cf_r[2] <= 36'(m12_r[68:36]) - 36'(f43e5[37:6]);
    cf_r[3] <= 36'(m96b_r[68:36]);
    cf_r[4] <= 36'(m960_r[74:41]);
  end

  assign cf_o = cf_r;

endmodule

/* hw/rtl/kepler_orbit_position_top.sv */
// Orbit position top level: config registers, anomaly math, series and position stages.
// Depends on kop_pkg, kop_coef, kop_cordic_chain and the assertion macro header.

// Takes one time tick per clock while the output is not stalled and returns one position
// beat per tick, in order. Two 30-cell rotation chains make up most of the pipeline: one
// (five lanes wide) for sin(k*M), one for cos/sin of the true anomaly. The whole data
// pipeline advances together and stalls only while an output beat waits.
// Coefficients follow the eccentricity register through the free-running kop_coef pipeline.
`include "kepler_orbit_position_top_assert.svh"

module kepler_orbit_position_top import kop_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_time_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_z,
  output logic [31:0] out_true_anomaly,
  output logic [31:0] out_spin_angle,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] start_r, rate_r, spin_rate_r;
  logic [15:0] ecc_r;
  logic [29:0] major_r, minor_r;

  logic [PipeStages-1:0] vld_r;
  logic                  en;

  logic [63:0]        pm_full, ps_full;
  logic [31:0]        pm_r, spin_a_r, m32_b_r, spin_b_r;
  logic [31:0]        mk [NumTerms];
  logic signed [32:0] cn1 [NumTerms];
  logic signed [32:0] sn1 [NumTerms];
  logic [63:0]        tag1 [NumTerms];
  coef_t              cf [NumTerms];

  logic signed [68:0] prod_r [NumTerms];
  logic [31:0]        m32_c_r, spin_c_r, m32_d_r, spin_d_r, m32_e_r, spin_e_r;
  logic signed [41:0] sum_nxt, sum_r;
  logic signed [74:0] dprod_r;
  logic [31:0]        nu_f_r, spin_f_r;

  logic signed [32:0] cn2, sn2;
  logic [63:0]        tag2;
  logic signed [63:0] pa_r, pb_r;
  logic [61:0]        ea_r;
  logic [31:0]        nu_g_r, spin_g_r;
  logic signed [35:0] xv, zv;
  logic [31:0]        px_r, pz_r, nu_h_r, spin_h_r;

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      rate_r      <= '0;
      ecc_r       <= '0;
      major_r     <= '0;
      minor_r     <= '0;
      spin_rate_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_START_ANOMALY: start_r     <= cfg_wdata;
        REG_ANOMALY_RATE:  rate_r      <= cfg_wdata;
        REG_ECCENTRICITY:  ecc_r       <= cfg_wdata[15:0];
        REG_SEMI_MAJOR:    major_r     <= cfg_wdata[29:0];
        REG_SEMI_MINOR:    minor_r     <= cfg_wdata[29:0];
        REG_SPIN_RATE:     spin_rate_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline advances unless the output beat is stuck
  assign en       = !vld_r[PipeStages-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PipeStages-2:0], in_valid};
    end
  end

  kop_coef u_coef (
    .clk  (clk),
    .ecc  (ecc_r),
    .cf_o (cf)
  );

  // mean anomaly and spin products
  assign pm_full = in_time_ticks * rate_r;
  assign ps_full = in_time_ticks * spin_rate_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pm_r     <= pm_full[31:0];
      spin_a_r <= ps_full[31:0];
      m32_b_r  <= start_r + pm_r;
      spin_b_r <= spin_a_r;
    end
  end

  // harmonics k*M for the series lanes
  assign mk[0] = m32_b_r;
  assign mk[1] = {m32_b_r[30:0], 1'b0};
  assign mk[2] = m32_b_r + {m32_b_r[30:0], 1'b0};
  assign mk[3] = {m32_b_r[29:0], 2'b00};
  assign mk[4] = m32_b_r + {m32_b_r[29:0], 2'b00};

  for (genvar k = 0; k < NumTerms; k++) begin : g_lane
    kop_cordic_chain u_chain (
      .clk   (clk),
      .en    (en),
      .ang_i (mk[k]),
      .tag_i ((k == 0) ? {m32_b_r, spin_b_r} : 64'h0),
      .cos_o (cn1[k]),
      .sin_o (sn1[k]),
      .tag_o (tag1[k])
    );
  end

  // series sum of the five terms
  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < NumTerms; k++) begin
      sum_nxt = sum_nxt + 42'(prod_r[k] >>> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NumTerms; k++) begin
        prod_r[k] <= 69'(cf[k] >>> 2) * 69'(sn1[k]);
      end
      m32_c_r  <= tag1[0][63:32];
      spin_c_r <= tag1[0][31:0];
      sum_r    <= sum_nxt;
      m32_d_r  <= m32_c_r;
      spin_d_r <= spin_c_r;
      dprod_r  <= 75'(sum_r >>> 2) * 75'(TwoOverPi);
      m32_e_r  <= m32_d_r;
      spin_e_r <= spin_d_r;
      nu_f_r   <= m32_e_r + dprod_r[61:30];
      spin_f_r <= spin_e_r;
    end
  end

  kop_cordic_chain u_nu_chain (
    .clk   (clk),
    .en    (en),
    .ang_i (nu_f_r),
    .tag_i ({nu_f_r, spin_f_r}),
    .cos_o (cn2),
    .sin_o (sn2),
    .tag_o (tag2)
  );

  // position scaling and saturation
  assign xv = 36'(pa_r >>> 30) - 36'(ea_r[61:32]);
  assign zv = -36'(pb_r >>> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r     <= 64'($signed({1'b0, major_r})) * 64'(cn2);
      pb_r     <= 64'($signed({1'b0, minor_r})) * 64'(sn2);
      ea_r     <= {ecc_r, 16'h0000} * major_r;
      nu_g_r   <= tag2[63:32];
      spin_g_r <= tag2[31:0];
      px_r     <= sat32(xv);
      pz_r     <= sat32(zv);
      nu_h_r   <= nu_g_r;
      spin_h_r <= spin_g_r;
    end
  end

  assign out_valid        = vld_r[PipeStages-1];
  assign out_pos_x        = px_r;
  assign out_pos_z        = pz_r;
  assign out_true_anomaly = nu_h_r;
  assign out_spin_angle   = spin_h_r;

  `KOP_ASSERT_IMP(a_no_take_when_full, out_valid && !out_ready, !in_ready, "input taken while output stalled")
  `KOP_ASSERT_NXT(a_hold_on_stall, !en, $stable(vld_r), "pipeline moved during stall")
  `KOP_ASSERT_IMP(a_out_from_pipe, $rose(out_valid), $past(vld_r[PipeStages-2]), "output beat without source")

endmodule

/* tb/kepler_orbit_position_top_tb.sv */
// Self-checking testbench for kepler_orbit_position_top: random and directed time ticks.
// A scoreboard class predicts each position beat in order; it depends on kop_pkg.
module kepler_orbit_position_top_tb;
  import kop_pkg::*;

  // indexes past the register file; writes there must be dropped
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int unsigned SettleCycles = PipeStages + 12;

  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_z;
    logic [31:0] true_anomaly;
    logic [31:0] spin_angle;
  } orbit_beat_t;

  // Predicts orbit beats and checks them in order
  class orbit_scoreboard;
    bit [31:0] start_anom, anom_rate, spin;
    bit [15:0] ecc;
    longint    axis_a, axis_b;
    orbit_beat_t pending[$];
    int errors;

    function new();
      start_anom = 0; anom_rate = 0; spin = 0; ecc = 0; axis_a = 0; axis_b = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_START_ANOMALY: start_anom = data;
        REG_ANOMALY_RATE:  anom_rate = data;
        REG_ECCENTRICITY:  ecc = data[15:0];
        REG_SEMI_MAJOR:    axis_a = longint'(data[29:0]);
        REG_SEMI_MINOR:    axis_b = longint'(data[29:0]);
        REG_SPIN_RATE:     spin = data;
        default: ;
      endcase
    endfunction

    // rotation in turns: cos and sin in Q1.30
    static function void rotate(input bit [31:0] ang, output longint c, output longint s);
      longint turn_atan [30] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
        'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
        'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
        'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
        'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
        'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};
      bit [31:0] probe;
      bit flip;
      longint x, y, z, nx;
      probe = ang + 32'h40000000;
      flip = probe[31];
      if (flip) ang = ang + 32'h80000000;
      x = 'h26DD3B6A;
      y = 0;
      z = longint'(signed'(ang));
      for (int i = 0; i < 30; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z = z - turn_atan[i];
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z = z + turn_atan[i];
        end
        x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    static function logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
    endfunction

    // accepted tick: work out the beat it causes
    function void note_tick(bit [31:0] t);
      bit [31:0] mean, nu;
      longint unsigned e1, e2, e3, e4, e5;
      longint terms [5];
      longint series, delta, cn, sn;
      orbit_beat_t b;
      mean = start_anom + t * anom_rate;
      e1 = longint'(ecc) << 16;
      e2 = (e1 * e1) >> 32; e3 = (e2 * e1) >> 32;
      e4 = (e3 * e1) >> 32; e5 = (e4 * e1) >> 32;
      terms[0] = longint'(2 * e1) - longint'(e3 >> 2) + longint'((5 * e5) / 96);
      terms[1] = longint'((5 * e2) / 4) - longint'((11 * e4) / 24);
      terms[2] = longint'((13 * e3) / 12) - longint'((43 * e5) / 64);
      terms[3] = longint'((103 * e4) / 96);
      terms[4] = longint'((1097 * e5) / 960);
      series = 0;
      for (int k = 0; k < 5; k++) begin
        rotate(mean * (k + 1), cn, sn);
        series += ((terms[k] >>> 2) * sn) >>> 30;
      end
      delta = ((series >>> 2) * 64'sh00000000A2F9836E) >>> 30;
      nu = mean + delta[31:0];
      rotate(nu, cn, sn);
      b.pos_x = clamp32(((axis_a * cn) >>> 30) - longint'((e1 * longint'(axis_a)) >> 32));
      b.pos_z = clamp32(-((axis_b * sn) >>> 30));
      b.true_anomaly = nu;
      b.spin_angle = t * spin;
      pending.push_back(b);
    endfunction

    function void check_beat(orbit_beat_t got);
      orbit_beat_t want;
      if (pending.size() == 0) begin
        $error("unexpected beat: pos_x %h pos_z %h", got.pos_x, got.pos_z);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.pos_x !== want.pos_x) begin
        $error("pos_x expected %h actual %h", want.pos_x, got.pos_x); errors++;
      end
      if (got.pos_z !== want.pos_z) begin
        $error("pos_z expected %h actual %h", want.pos_z, got.pos_z); errors++;
      end
      if (got.true_anomaly !== want.true_anomaly) begin
        $error("true_anomaly expected %h actual %h", want.true_anomaly, got.true_anomaly);
        errors++;
      end
      if (got.spin_angle !== want.spin_angle) begin
        $error("spin_angle expected %h actual %h", want.spin_angle, got.spin_angle);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_time_ticks = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_pos_x, out_pos_z, out_true_anomaly, out_spin_angle;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;

  orbit_scoreboard sb = new();
  bit calm = 1'b0;       // no idling on either side
  int rx_hold = 0;       // one-shot long receiver stall

  kepler_orbit_position_top u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_time_ticks,
    .out_valid, .out_ready, .out_pos_x, .out_pos_z, .out_true_anomaly, .out_spin_angle,
    .cfg_we, .cfg_idx, .cfg_wdata
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  // result side: stall per beat, then take it
  initial begin : receiver
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
      end else begin
        n = calm ? 0 : $urandom_range(0, 16);
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // check each accepted beat
  always @(posedge clk) begin
    orbit_beat_t got;
    if (rst_n && out_valid && out_ready) begin
      got.pos_x = out_pos_x;
      got.pos_z = out_pos_z;
      got.true_anomaly = out_true_anomaly;
      got.spin_angle = out_spin_angle;
      sb.check_beat(got);
    end
  end

  task automatic send_tick(bit [31:0] t);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_time_ticks <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(t);
  endtask

  // wait for the pipe to drain, then let it go quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic load_orbit(bit [31:0] st, bit [31:0] rate, bit [31:0] e,
                            bit [31:0] a, bit [31:0] b, bit [31:0] sp);
    drain();
    write_reg(REG_START_ANOMALY, st);
    write_reg(REG_ANOMALY_RATE, rate);
    write_reg(REG_ECCENTRICITY, e);
    write_reg(REG_SEMI_MAJOR, a);
    write_reg(REG_SEMI_MINOR, b);
    write_reg(REG_SPIN_RATE, sp);
    repeat (12) @(posedge clk);
  endtask

  task automatic random_ticks(int count);
    for (int i = 0; i < count; i++) begin
      send_tick($urandom());
    end
  endtask

  initial begin : main
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: everything zero
    send_tick(32'h0);
    send_tick(32'hFFFF_FFFF);

    // quadrant boundaries of the mean anomaly, circular orbit
    load_orbit(32'h0, 32'h4000_0000, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h1);
    for (int t = 0; t < 5; t++) send_tick(t);
    send_tick(32'h8000_0000);
    send_tick(32'h7FFF_FFFF);

    // all ones: masked widths, max eccentricity, saturating axes
    load_orbit('1, '1, '1, '1, '1, '1);
    send_tick(32'h0);
    send_tick(32'h1);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'h2000_0000);
    send_tick(32'h5555_5555);

    // spare indexes must leave the registers alone
    drain();
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, 32'h1234_5678);
    repeat (12) @(posedge clk);
    send_tick(32'hAAAA_AAAA);
    send_tick(32'h0000_0003);

    // half-range orbit, mid eccentricity
    load_orbit(32'h1000_0000, 32'h0100_0000, 32'h8000, 32'h2000_0000, 32'h1000_0000,
               32'h8000_0001);
    for (int t = 0; t < 6; t++) send_tick(t * 37);

    // random orbits
    for (int p = 0; p < 4; p++) begin
      load_orbit($urandom(), $urandom(),
                 (p == 0) ? $urandom_range(0, 16'h3000) : $urandom(),
                 $urandom(), $urandom(), $urandom());
      random_ticks(110);
    end

    // back pressure: long output stall while ticks keep coming
    load_orbit($urandom(), $urandom(), $urandom_range(0, 16'hFFFF),
               $urandom_range(0, 32'h0FFF_FFFF), $urandom_range(0, 32'h0FFF_FFFF),
               $urandom());
    calm = 1'b1;
    rx_hold = 300;
    random_ticks(120);
    calm = 1'b0;

    // sender pause until all beats are back, then a last random set
    drain();
    random_ticks(60);

    drain();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
